// ===== rtl/core/scfp_pkg.sv =====
// Package with the shared types and constants of the serial command frame parser.
package scfp_pkg;

  localparam int unsigned SELECT_ENTRIES = 9;
  localparam int unsigned FRAME_BYTES    = 5;
  // The last payload byte is not stored; it is used straight from the input register.
  localparam int unsigned STORE_DEPTH    = FRAME_BYTES - 1;
  localparam int unsigned CNT_W          = 3;
  localparam int unsigned IDX_W          = 4;

  localparam logic [CNT_W-1:0] LAST_CNT    = CNT_W'(FRAME_BYTES - 1);
  localparam logic [7:0]       SEL_LIMIT   = 8'(SELECT_ENTRIES);

  localparam logic [7:0] HDR_BYTE    = 8'hF0;
  localparam logic [7:0] SW_ON_BYTE  = 8'h0A;
  localparam logic [7:0] SW_OFF_BYTE = 8'hB0;
  localparam logic [7:0] MODE_DROP   = 8'h00;
  localparam logic [7:0] MODE_SELECT = 8'h01;
  localparam logic [7:0] MODE_SWITCH = 8'h02;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MODE,
    PH_COLLECT0,
    PH_COLLECT1,
    PH_COLLECT2
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_DROPPED,
    ST_SEL_OK,
    ST_BAD_INDEX,
    ST_SW_ON,
    ST_SW_OFF,
    ST_SW_REJECT
  } status_e;

  typedef struct packed {
    logic             switch_on;
    logic             select_write;
    logic [IDX_W-1:0] select_index;
    logic [7:0]       select_value;
    status_e          frame_status;
  } result_t;

endpackage

// ===== rtl/core/scfp_if.sv =====
// Handshake interfaces for the received byte and the per-byte result.
interface scfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfp_result_if;
  logic       valid;
  logic       ready;
  logic       switch_on;
  logic       select_write;
  logic [3:0] select_index;
  logic [7:0] select_value;
  logic [2:0] frame_status;

  modport source (
    output valid, output switch_on, output select_write, output select_index,
    output select_value, output frame_status, input ready
  );
  modport sink (
    input valid, input switch_on, input select_write, input select_index,
    input select_value, input frame_status, output ready
  );
endinterface

// ===== rtl/core/scfp_f2u.sv =====
// Conversion of IEEE single bits to an unsigned byte, truncated and saturated.
module scfp_f2u (
  input  logic [31:0] bits_i,
  output logic [7:0]  value_o
);
  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [7:0] EXP_SAT  = 8'd135;
  localparam logic [7:0] EXP_SPEC = 8'hFF;

  logic       sign;
  logic [7:0] expo;
  logic [22:0] mant;
  logic [2:0] rsh;

  assign sign = bits_i[31];
  assign expo = bits_i[30:23];
  assign mant = bits_i[22:0];
  // Unbiased exponent e lies in 0..7 on the normal path; shift right by 7 - e.
  assign rsh  = 3'(EXP_SAT - 8'd1 - expo);

  always_comb begin
    if (expo == EXP_SPEC) begin
      value_o = (mant != '0 || sign) ? 8'd0 : 8'd255;
    end else if (sign || expo < EXP_BIAS) begin
      value_o = 8'd0;
    end else if (expo >= EXP_SAT) begin
      value_o = 8'd255;
    end else begin
      value_o = {1'b1, mant[22:16]} >> rsh;
    end
  end
endmodule

// ===== rtl/core/scfp_core.sv =====
// Frame parser state machine: phase, byte count, payload store and switch flag.
module scfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output scfp_pkg::result_t result_o
);
  import scfp_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             flag_q, flag_d;
  logic [7:0]       frame_store [STORE_DEPTH];
  logic             collecting;
  logic             last_byte;
  logic [7:0]       fval;
  logic             all_on;
  logic             all_off;

  assign collecting = phase_q inside {PH_COLLECT0, PH_COLLECT1, PH_COLLECT2};
  assign last_byte  = collecting && (count_q == LAST_CNT);

  scfp_f2u u_f2u (
    .bits_i  ({frame_store[1], frame_store[2], frame_store[3], byte_i}),
    .value_o (fval)
  );

  always_comb begin
    all_on  = (byte_i == SW_ON_BYTE);
    all_off = (byte_i == SW_OFF_BYTE);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      all_on  = all_on && (frame_store[i] == SW_ON_BYTE);
      all_off = all_off && (frame_store[i] == SW_OFF_BYTE);
    end
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    case (phase_q)
      PH_IDLE: begin
        if (byte_i == HDR_BYTE) phase_d = PH_MODE;
      end
      PH_MODE: begin
        count_d = '0;
        case (byte_i)
          MODE_DROP:   phase_d = PH_COLLECT0;
          MODE_SELECT: phase_d = PH_COLLECT1;
          MODE_SWITCH: phase_d = PH_COLLECT2;
          default:     phase_d = PH_MODE;
        endcase
      end
      PH_COLLECT0, PH_COLLECT1, PH_COLLECT2: begin
        if (last_byte) begin
          phase_d = PH_IDLE;
          count_d = '0;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      default: begin
        phase_d = PH_IDLE;
        count_d = '0;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    flag_d                = flag_q;
    result_o.select_write = 1'b0;
    result_o.select_index = '0;
    result_o.select_value = '0;
    result_o.frame_status = ST_NONE;
    if (last_byte) begin
      case (phase_q)
        PH_COLLECT0: result_o.frame_status = ST_DROPPED;
        PH_COLLECT1: begin
          if (frame_store[0] < SEL_LIMIT) begin
            result_o.select_write = 1'b1;
            result_o.select_index = frame_store[0][IDX_W-1:0];
            result_o.select_value = fval;
            result_o.frame_status = ST_SEL_OK;
          end else begin
            result_o.frame_status = ST_BAD_INDEX;
          end
        end
        PH_COLLECT2: begin
          if (all_on) begin
            flag_d                = 1'b1;
            result_o.frame_status = ST_SW_ON;
          end else if (all_off) begin
            flag_d                = 1'b0;
            result_o.frame_status = ST_SW_OFF;
          end else begin
            result_o.frame_status = ST_SW_REJECT;
          end
        end
        default: result_o.frame_status = ST_NONE;
      endcase
    end
    result_o.switch_on = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      flag_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && collecting && !last_byte) begin
      frame_store[count_q[1:0]] <= byte_i;
    end
  end

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE || phase_q == PH_MODE) |-> count_q == '0)
    else $error("byte count not cleared outside a frame");

  a_frame_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.frame_status != ST_NONE) |=> phase_q == PH_IDLE)
    else $error("parser did not return to idle after a frame");

  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.select_write |-> (result_o.frame_status == ST_SEL_OK && phase_q == PH_COLLECT1))
    else $error("select write outside a good select frame");

  a_flag_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.frame_status == ST_SW_ON) |=> flag_q)
    else $error("switch flag not set after an on frame");

  a_flag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.frame_status != ST_SW_ON && result_o.frame_status != ST_SW_OFF)
      |=> flag_q == $past(flag_q))
    else $error("switch flag changed without a switch frame");
endmodule

// ===== rtl/core/serial_command_frame_parser.sv =====
// Top level of the serial command frame parser: input register, parser and result register.
// Each accepted byte yields exactly one result: the byte is held in the input register,
// then passes through the parser into the result register. A byte can be accepted every
// cycle while the output is not stalled; the input register and the result register
// together let a new byte enter while a finished result still waits to be taken. A frame
// is the header byte 0xF0, a mode byte (0, 1 or 2; other bytes are skipped), and five
// payload bytes. Mode 1 reports an index and a float converted to an unsigned byte with
// truncation and saturation; mode 2 switches the on/off flag; mode 0 frames are dropped.
module serial_command_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  scfp_byte_if.sink  in_i,
  scfp_result_if.source res_o
);
  import scfp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       res_valid_q;
  result_t    res_q;
  result_t    core_res;
  logic       step;

  // The parser advances when a request is held and the result register is free or being emptied.
  assign step       = in_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready = !in_valid_q || step;

  scfp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (step) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_byte_q <= in_i.rx_byte;
    if (step) res_q <= core_res;
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.switch_on    = res_q.switch_on;
  assign res_o.select_write = res_q.select_write;
  assign res_o.select_index = res_q.select_index;
  assign res_o.select_value = res_q.select_value;
  assign res_o.frame_status = res_q.frame_status;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready) |=> (res_valid_q && $stable(res_q)))
    else $error("pending result overwritten");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("held request lost before the parser took it");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> res_valid_q)
    else $error("parser step did not fill the result register");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the serial command frame parser.
`timescale 1ns / 100ps

module tb;
  import scfp_pkg::*;

  // Predicts the parser result for every accepted byte and checks the results in order.
  class frame_checker;
    phase_e      phase;
    int unsigned fill;
    logic [7:0]  payload [FRAME_BYTES];
    logic        switch_flag;
    logic [7:0]  select_table [SELECT_ENTRIES];
    result_t     expected_results [$];
    int unsigned failures;
    int unsigned bytes_seen;
    int unsigned results_seen;
    int unsigned status_seen [8];

    function new();
      phase       = PH_IDLE;
      fill        = 0;
      switch_flag = 1'b0;
      foreach (select_table[i]) select_table[i] = 8'(i);
      foreach (payload[i]) payload[i] = 8'h00;
      foreach (status_seen[i]) status_seen[i] = 0;
      failures     = 0;
      bytes_seen   = 0;
      results_seen = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [31:0] bits;
      logic [7:0]  val;
      int          on_cnt;
      int          off_cnt;
      r = '0;
      bytes_seen++;
      case (phase)
        PH_IDLE: begin
          if (b == HDR_BYTE) phase = PH_MODE;
        end
        PH_MODE: begin
          fill = 0;
          if (b == MODE_DROP) phase = PH_COLLECT0;
          else if (b == MODE_SELECT) phase = PH_COLLECT1;
          else if (b == MODE_SWITCH) phase = PH_COLLECT2;
        end
        default: begin
          payload[fill] = b;
          fill++;
          if (fill == FRAME_BYTES) begin
            if (phase == PH_COLLECT0) begin
              r.frame_status = ST_DROPPED;
            end else if (phase == PH_COLLECT1) begin
              if (payload[0] < SELECT_ENTRIES) begin
                bits = {payload[1], payload[2], payload[3], payload[4]};
                // Truncate toward zero; negative and NaN give zero, large values saturate.
                if (bits[30:23] == 8'hFF) begin
                  val = (bits[22:0] != 0 || bits[31]) ? 8'h00 : 8'hFF;
                end else if (bits[31] || bits[30:23] < 8'd127) begin
                  val = 8'h00;
                end else if (bits[30:23] >= 8'd135) begin
                  val = 8'hFF;
                end else begin
                  val = 8'({1'b1, bits[22:0]} >> (150 - int'(bits[30:23])));
                end
                select_table[payload[0]] = val;
                r.select_write = 1'b1;
                r.select_index = payload[0][3:0];
                r.select_value = val;
                r.frame_status = ST_SEL_OK;
              end else begin
                r.frame_status = ST_BAD_INDEX;
              end
            end else begin
              on_cnt  = 0;
              off_cnt = 0;
              foreach (payload[i]) begin
                if (payload[i] == SW_ON_BYTE) on_cnt++;
                if (payload[i] == SW_OFF_BYTE) off_cnt++;
              end
              if (on_cnt == FRAME_BYTES) begin
                switch_flag    = 1'b1;
                r.frame_status = ST_SW_ON;
              end else if (off_cnt == FRAME_BYTES) begin
                switch_flag    = 1'b0;
                r.frame_status = ST_SW_OFF;
              end else begin
                r.frame_status = ST_SW_REJECT;
              end
            end
            phase = PH_IDLE;
            fill  = 0;
          end
        end
      endcase
      r.switch_on = switch_flag;
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      status_seen[int'(got.frame_status)]++;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with no pending request: status %0d", $realtime,
                   got.frame_status);
        return;
      end
      want = expected_results.pop_front();
      if (got.switch_on !== want.switch_on || got.select_write !== want.select_write ||
          got.select_index !== want.select_index ||
          got.select_value !== want.select_value ||
          got.frame_status !== want.frame_status) begin
        failures++;
        if (failures <= 10) begin
          $write("%0t: mismatch: expected on=%b wr=%b idx=%0d val=%0d st=%0d", $realtime,
                 want.switch_on, want.select_write, want.select_index,
                 want.select_value, want.frame_status);
          $display(", got on=%b wr=%b idx=%0d val=%0d st=%0d", got.switch_on,
                   got.select_write, got.select_index, got.select_value,
                   got.frame_status);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  scfp_byte_if   byte_if ();
  scfp_result_if res_if ();

  serial_command_frame_parser uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .res_o (res_if)
  );

  frame_checker sb = new();
  int unsigned  sent_count  = 0;
  int unsigned  frame_bytes = 0;
  logic [7:0]   opening_bytes [25];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = ((sent_count % 150) < 40) ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      byte_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    do @(posedge clk_i); while (byte_if.ready !== 1'b1);
    sb.note_byte(b);
    sent_count++;
  endtask

  // Mostly well-formed frames with random content, plus idle noise and bad mode bytes.
  task automatic random_frame();
    int          kind;
    int          mode_pick;
    int          pos;
    logic [7:0]  base;
    logic [31:0] bits;
    logic [7:0]  pl [FRAME_BYTES];
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      return;
    end
    send_byte(HDR_BYTE);
    if (kind < 18) repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(3, 255)));
    mode_pick = $urandom_range(0, 99);
    if (mode_pick < 45) begin
      send_byte(MODE_SELECT);
      case ($urandom_range(0, 8))
        0: bits = {1'b0, 8'($urandom_range(127, 134)), 23'($urandom)};
        1: bits = {1'b0, 8'($urandom_range(0, 126)), 23'($urandom)};
        2: bits = {1'b1, 31'($urandom)};
        3: bits = {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
        4: bits = {1'($urandom), 8'hFF, 23'h0};
        5: bits = {1'b0, 8'($urandom_range(135, 254)), 23'($urandom)};
        6: bits = {16'h437F, 16'($urandom)};
        7: begin
          case ($urandom_range(0, 3))
            0: bits = 32'h4380_0000;
            1: bits = 32'h437F_0000;
            2: bits = 32'h3F80_0000;
            default: bits = {1'($urandom), 31'h0};
          endcase
        end
        default: bits = $urandom;
      endcase
      pl[0] = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, SELECT_ENTRIES - 1))
                                           : 8'($urandom_range(SELECT_ENTRIES, 255));
      pl[1] = bits[31:24];
      pl[2] = bits[23:16];
      pl[3] = bits[15:8];
      pl[4] = bits[7:0];
    end else if (mode_pick < 80) begin
      send_byte(MODE_SWITCH);
      base = $urandom_range(0, 1) ? SW_ON_BYTE : SW_OFF_BYTE;
      foreach (pl[i]) pl[i] = base;
      case ($urandom_range(0, 3))
        0: foreach (pl[i]) pl[i] = SW_ON_BYTE;
        1: foreach (pl[i]) pl[i] = SW_OFF_BYTE;
        2: begin
          pos     = $urandom_range(0, FRAME_BYTES - 1);
          pl[pos] = base ^ 8'($urandom_range(1, 255));
        end
        default: foreach (pl[i]) pl[i] = 8'($urandom);
      endcase
    end else begin
      send_byte(MODE_DROP);
      foreach (pl[i]) pl[i] = 8'($urandom);
    end
    foreach (pl[i]) send_byte(pl[i]);
    frame_bytes += FRAME_BYTES + 2;
  endtask

  initial begin
    byte_if.valid   = 1'b0;
    byte_if.rx_byte = 8'h00;
    rst_ni          = 1'b0;
    // Idle noise, an unknown mode byte, a repeated header in the mode slot, a dropped
    // frame, a select write at the top index with a value just under 256, a switch-on.
    opening_bytes = '{8'h00, 8'hFF, HDR_BYTE, 8'h07, HDR_BYTE, MODE_DROP,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      HDR_BYTE, MODE_SELECT, 8'h08, 8'h43, 8'h7F, 8'h80, 8'h00,
                      HDR_BYTE, MODE_SWITCH, SW_ON_BYTE, SW_ON_BYTE, SW_ON_BYTE,
                      SW_ON_BYTE, SW_ON_BYTE};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    while (frame_bytes < 700) random_frame();
    @(negedge clk_i);
    byte_if.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes (%0d in random frames) and checked %0d results.",
             sb.bytes_seen, frame_bytes, sb.results_seen);
    $write("Frames seen: %0d dropped, %0d select writes, %0d bad index, ",
           sb.status_seen[ST_DROPPED], sb.status_seen[ST_SEL_OK],
           sb.status_seen[ST_BAD_INDEX]);
    $display("%0d on, %0d off, %0d rejected.", sb.status_seen[ST_SW_ON],
             sb.status_seen[ST_SW_OFF], sb.status_seen[ST_SW_REJECT]);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches, and two long hold-offs that back up the input.
  initial begin
    result_t got;
    int      stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ((sb.results_seen % 120) < 30) ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      got.switch_on    = res_if.switch_on;
      got.select_write = res_if.select_write;
      got.select_index = res_if.select_index;
      got.select_value = res_if.select_value;
      got.frame_status = status_e'(res_if.frame_status);
      sb.check_result(got);
      if (sb.results_seen == 150 || sb.results_seen == 480) begin
        repeat (300) begin
          @(negedge clk_i);
          res_if.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/scfp_pkg.sv
rtl/core/scfp_if.sv
rtl/core/scfp_f2u.sv
rtl/core/scfp_core.sv
rtl/core/serial_command_frame_parser.sv
tb/tb.sv
